[rtl/fm_pkg.sv]
// Package for the hardware mutex with a FIFO wait queue.
// Holds default sizes, status codes and the sequencer state type.
// No dependencies.
package fm_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_PID_BITS    = 8;

   // Widths of the transfer fields on the ports.
   localparam int PID_W    = 8;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;
   localparam int RSP_W    = 32;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED  = 3'd0,
      ST_ALREADY  = 3'd1,
      ST_QUEUED   = 3'd2,
      ST_DROPPED  = 3'd3,
      ST_RELEASED = 3'd4,
      ST_HANDOFF  = 3'd5,
      ST_IGNORED  = 3'd6
   } status_type;

   typedef enum logic {
      OP_LOCK   = 1'b0,
      OP_UNLOCK = 1'b1
   } op_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_EXEC
   } seq_type;

endpackage

[rtl/fifo_handoff_mutex.sv]
// Hardware mutex with a FIFO queue of waiting ids. Each lock or unlock
// request gives one response carrying status, the woken waiter, and the
// lock state after the request. In the cycle a request is accepted the
// queue head is read from the wait queue memory, whose read is registered;
// once the response slot is free the request is resolved in the exec state,
// the queue written or popped and the response registered. The block takes
// no new request until the last one is resolved, so a held response stalls
// both the resolution of the pending request and the acceptance of the next.
// Requires fm_pkg and fm_waitq_mem.
module fifo_handoff_mutex #(
   parameter int QUEUE_DEPTH = fm_pkg::DEF_QUEUE_DEPTH,
   parameter int PID_BITS    = fm_pkg::DEF_PID_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [fm_pkg::PID_W-1:0] req_tdata,  // [7:0] pid
   input  logic                     req_tuser,  // [0] op
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [2:0] status, [3] woke_valid, [11:4] woke_pid, [12] is_locked,
   // [20:13] current_owner, [25:21] waiting_count, [31:26] zero
   output logic [fm_pkg::RSP_W-1:0] rsp_tdata
);
   import fm_pkg::*;

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

   seq_type               state_ff, state_in;
   logic                  held_ff, held_in;
   logic [PID_BITS-1:0]   owner_ff, owner_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   op_type                op_ff;
   logic [PID_BITS-1:0]   pid_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  commit;
   logic                  push;
   logic [PID_BITS-1:0]   head_pid;
   status_type            status;
   logic                  woke_valid;
   logic [PID_BITS-1:0]   woke_pid;

   fm_waitq_mem #(
      .DEPTH  (QUEUE_DEPTH),
      .WIDTH  (PID_BITS),
      .ADDR_W (PTR_W)
   ) u_waitq (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (pid_ff),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (head_pid)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         held_ff      <= 1'b0;
         owner_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         owner_ff     <= owner_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= op_type'(req_tuser);
         pid_ff <= PID_BITS'(req_tdata);
      end
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Sequencer: accept in idle, resolve once the response slot is free.
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      commit     = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = SEQ_EXEC;
            end
         end
         SEQ_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               commit   = 1'b1;
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // Request resolution against the registered state and the queue head.
   always_comb begin
      held_in    = held_ff;
      owner_in   = owner_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      fill_in    = fill_ff;
      push       = 1'b0;
      woke_valid = 1'b0;
      woke_pid   = '0;
      status     = ST_IGNORED;
      if (op_ff == OP_LOCK) begin
         if (!held_ff) begin
            status = ST_GRANTED;
            if (commit) begin
               held_in  = 1'b1;
               owner_in = pid_ff;
            end
         end else if (owner_ff == pid_ff) begin
            status = ST_ALREADY;
         end else if (fill_ff == FULL_FILL) begin
            status = ST_DROPPED;
         end else begin
            status = ST_QUEUED;
            if (commit) begin
               push    = 1'b1;
               tail_in = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
               fill_in = fill_ff + 1'b1;
            end
         end
      end else if (held_ff && owner_ff == pid_ff) begin
         if (fill_ff != '0) begin
            status     = ST_HANDOFF;
            woke_valid = 1'b1;
            woke_pid   = head_pid;
            if (commit) begin
               owner_in = head_pid;
               head_in  = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
               fill_in  = fill_ff - 1'b1;
            end
         end else begin
            status = ST_RELEASED;
            if (commit) begin
               held_in  = 1'b0;
               owner_in = '0;
            end
         end
      end
   end

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[2:0]   = status;
      rsp_data_in[3]     = woke_valid;
      rsp_data_in[11:4]  = PID_W'(woke_pid);
      rsp_data_in[12]    = held_in;
      rsp_data_in[20:13] = PID_W'(owner_in);
      rsp_data_in[25:21] = COUNT_W'(fill_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (commit) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The queue never holds more entries than it has slots.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_FILL)
      else $error("wait queue fill exceeds depth");

   // Waiters can only exist while the mutex is held.
   a_free_empty: assert property (@(posedge clock) disable iff (reset)
      !held_ff |-> fill_ff == '0)
      else $error("waiters queued on a free mutex");

   // An accepted request moves the sequencer to the exec state in the following cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == SEQ_EXEC)
      else $error("accepted request not resolved");

   // A woken waiter is reported exactly with a handoff status.
   a_woke_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[3] == (rsp_data_ff[2:0] == ST_HANDOFF)))
      else $error("woke flag disagrees with status");

endmodule

[rtl/fm_waitq_mem.sv]
// Wait queue storage of the mutex: one write port, one read port with a
// registered read. No package dependencies.
module fm_waitq_mem #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sim/tb_fifo_handoff_mutex.sv]
// Self-checking testbench for fifo_handoff_mutex: directed and random lock and
// unlock requests, with responses checked field by field against a predictor.
// Depends on fm_pkg and the RTL of fifo_handoff_mutex.
`timescale 1ns / 100ps

module tb_fifo_handoff_mutex;
   import fm_pkg::*;

   localparam int RANDOM_ITEMS = 1520;
   localparam logic [PID_W-1:0] PID_MASK = PID_W'((1 << DEF_PID_BITS) - 1);

   typedef struct {
      status_type         status;
      bit                 woke_valid;
      bit [PID_W-1:0]     woke_pid;
      bit                 is_locked;
      bit [PID_W-1:0]     owner;
      bit [COUNT_W-1:0]   waiting;
   } mutex_rsp_type;

   // Predicts each response from its own copy of the lock flag, the owner and
   // the wait queue, and matches responses against the predictions in order.
   class mutex_scoreboard_type;
      bit                 held;
      bit [PID_W-1:0]     owner;
      bit [PID_W-1:0]     waiters[$];
      mutex_rsp_type      expected_q[$];
      int                 errors;

      function void note_request(op_type op, logic [PID_W-1:0] pid_raw);
         mutex_rsp_type  r;
         bit [PID_W-1:0] pid;
         pid = pid_raw & PID_MASK;
         r.woke_valid = 1'b0;
         r.woke_pid   = '0;
         if (op == OP_LOCK) begin
            if (!held) begin
               held     = 1'b1;
               owner    = pid;
               r.status = ST_GRANTED;
            end else if (owner == pid) begin
               r.status = ST_ALREADY;
            end else if (waiters.size() >= DEF_QUEUE_DEPTH) begin
               r.status = ST_DROPPED;
            end else begin
               waiters.insert(waiters.size(), pid);
               r.status = ST_QUEUED;
            end
         end else begin
            if (held && owner == pid) begin
               if (waiters.size() > 0) begin
                  owner        = waiters.pop_front();
                  r.woke_valid = 1'b1;
                  r.woke_pid   = owner;
                  r.status     = ST_HANDOFF;
               end else begin
                  held     = 1'b0;
                  owner    = '0;
                  r.status = ST_RELEASED;
               end
            end else begin
               r.status = ST_IGNORED;
            end
         end
         r.is_locked = held;
         r.owner     = held ? owner : '0;
         r.waiting   = COUNT_W'(waiters.size());
         expected_q.insert(expected_q.size(), r);
      endfunction

      function void compare_field(string name, int exp_val, int act_val);
         if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_response(logic [RSP_W-1:0] data);
         mutex_rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, data);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         compare_field("status",        int'(e.status),  data[2:0]);
         compare_field("woke_valid",    e.woke_valid,    data[3]);
         compare_field("woke_pid",      e.woke_pid,      data[11:4]);
         compare_field("is_locked",     e.is_locked,     data[12]);
         compare_field("current_owner", e.owner,         data[20:13]);
         compare_field("waiting_count", e.waiting,       data[25:21]);
         compare_field("padding",       0,               data[31:26]);
      endfunction
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [PID_W-1:0]   req_tdata  = '0;
   logic               req_tuser  = OP_LOCK;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b1;
   logic [RSP_W-1:0]   rsp_tdata;

   mutex_scoreboard_type sb;

   fifo_handoff_mutex DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Receiver back-pressure: the stall pattern switches between random modes,
   // including stretches where it never stalls.
   int unsigned stall_mode = 0;
   int unsigned mode_left  = 100;
   int unsigned phase_cnt  = 0;

   always @(posedge clock) begin
      phase_cnt <= phase_cnt + 1;
      if (reset) begin
         rsp_tready <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(3);
            mode_left  <= $urandom_range(256, 64);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(1));
            2: rsp_tready <= (phase_cnt % 5) < 3;
            default: rsp_tready <= ($urandom_range(7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
   end

   task automatic send_request(op_type op, logic [PID_W-1:0] pid);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= pid;
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, pid);
   endtask

   task automatic pause_sender(int unsigned cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned      sent;
      int unsigned      burst_len;
      int unsigned      burst_idx;
      int unsigned      lock_pct;
      int unsigned      roll;
      logic [PID_W-1:0] pool[4];
      logic [PID_W-1:0] pid;
      op_type           op;

      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Unlock of a free mutex is ignored even when the pid equals the stored owner.
      send_request(OP_UNLOCK, 8'd0);
      send_request(OP_LOCK,   8'd0);
      send_request(OP_LOCK,   8'd0);
      send_request(OP_UNLOCK, 8'd255);
      send_request(OP_LOCK,   8'd255);
      // A waiting id that asks again is queued a second time.
      send_request(OP_LOCK,   8'd255);
      send_request(OP_UNLOCK, 8'd0);
      send_request(OP_UNLOCK, 8'd255);
      send_request(OP_UNLOCK, 8'd255);
      send_request(OP_UNLOCK, 8'd255);
      // Fill the wait queue, then overflow it.
      send_request(OP_LOCK,   8'h55);
      for (int i = 0; i < DEF_QUEUE_DEPTH; i++)
         send_request(OP_LOCK, 8'(i * 17 + 1));
      send_request(OP_LOCK,   8'hAA);
      send_request(OP_LOCK,   8'h55);
      wait_drained();

      sent      = 0;
      burst_idx = 0;
      lock_pct  = 50;
      while (sent < RANDOM_ITEMS) begin
         if (burst_idx % 4 == 0) begin
            case ($urandom_range(2))
               0: lock_pct = 25;
               1: lock_pct = 50;
               default: lock_pct = 80;
            endcase
            pool[0] = 8'd0;
            pool[1] = 8'd255;
            pool[2] = PID_W'($urandom_range(255));
            pool[3] = PID_W'($urandom_range(255));
         end
         burst_idx++;
         burst_len = $urandom_range(20, 1);
         for (int k = 0; k < burst_len && sent < RANDOM_ITEMS; k++) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
               op  = op_type'($urandom_range(1));
               pid = PID_W'($urandom_range(255));
            end else if (roll < lock_pct) begin
               op  = OP_LOCK;
               pid = pool[$urandom_range(3)];
            end else begin
               op  = OP_UNLOCK;
               if (sb.held && $urandom_range(9) < 8)
                  pid = sb.owner;
               else
                  pid = pool[$urandom_range(3)];
            end
            send_request(op, pid);
            sent++;
            if (sent % 400 == 0)
               wait_drained();
         end
         if ($urandom_range(3) != 0)
            pause_sender($urandom_range(12, 1));
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #400000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
